// ===== hw/rtl/crim_pkg.sv =====
`default_nettype none

package crim_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned POS_W = 21;
	localparam int unsigned NP_W  = 22;
	localparam int unsigned ENT_W = 9;

	localparam logic [CP_W-1:0] MAX_CODE_POINT = 21'h10FFFF;
	localparam logic [NP_W:0]   POS_LIMIT      = 23'h200000;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_POS2CP = 3'd2,
		OP_CP2POS = 3'd3,
		OP_LAST   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_RANGE = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_BRD,
		S_BCHK,
		S_LRD,
		S_LCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [CP_W-1:0]  range_start;
		logic [CP_W-1:0]  range_end;
		logic [POS_W-1:0] position;
		logic [CP_W-1:0]  code_point;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [CP_W-1:0]  code_point_out;
		logic [POS_W-1:0] position_out;
		logic [ENT_W-1:0] entries_used;
	} rsp_t;

	typedef struct packed {
		logic [CP_W-1:0]  rng_start;
		logic [CP_W-1:0]  rng_end;
		logic [POS_W-1:0] rng_base;
	} entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/codepoint_range_index_map.sv =====
`default_nettype none

// channel | beat     | valid     | stall     | accepted when
// req     | req_t    | req_valid | req_stall | req_valid & !req_stall
// rsp     | rsp_t    | rsp_valid | rsp_stall | rsp_valid & !rsp_stall
//
// One request at a time, each taken only in the idle state. Clear, append, last
// position and bad ops: the response follows the execute and done states. Position
// lookup: binary search, each probe a read state and a check state (one read port,
// registered read). Code point lookup: linear scan, a read and a check per range.
// Reset clears the count and the running position; the range memory is not
// cleared. A stalled response holds; the next request is taken meanwhile.

module codepoint_range_index_map #(
	parameter int unsigned MAX_RANGES = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  crim_pkg::req_t   req,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output crim_pkg::rsp_t   rsp
);
	import crim_pkg::*;

	localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CW = $clog2(MAX_RANGES + 1);

	state_t state_q, state_n;

	req_t            req_q;
	entry_t          range_mem_q [MAX_RANGES];
	entry_t          rd_data_q;
	logic [CW-1:0]   total_q;
	logic [NP_W-1:0] npos_q;
	logic [CW-1:0]   lo_q, hx_q, mid_q, idx_q;
	logic [2:0]      pend_status_q;
	logic [CP_W-1:0] pend_cp_q;
	logic [POS_W-1:0] pend_pos_q;
	logic            rsp_vld_q;
	rsp_t            rsp_q;

	logic            mem_we;
	logic            mem_re;
	logic [AW-1:0]   rd_addr;
	logic [CW:0]     mid_sum;
	logic [CW-1:0]   mid_c;
	logic [NP_W-1:0] app_size;
	logic [NP_W:0]   app_sum;
	logic            app_bad, app_full, app_ovf;
	logic [POS_W-1:0] b_last;
	logic            b_above, b_below, b_hit;
	logic [CW-1:0]   lo_n, hx_n;
	logic            l_hit;
	logic [CW-1:0]   idx_n;
	logic            rsp_free;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hx_q} - (CW+1)'(1);
	assign mid_c    = mid_sum[CW:1];
	assign app_size = NP_W'(req_q.range_end) - NP_W'(req_q.range_start) + NP_W'(1);
	assign app_sum  = {1'b0, npos_q} + {1'b0, app_size};
	assign app_bad  = (req_q.range_end > MAX_CODE_POINT) ||
		(req_q.range_start > req_q.range_end);
	assign app_full = total_q >= CW'(MAX_RANGES);
	assign app_ovf  = app_sum > POS_LIMIT;

	assign b_last  = rd_data_q.rng_base + (rd_data_q.rng_end - rd_data_q.rng_start);
	assign b_above = req_q.position > b_last;
	assign b_below = req_q.position < rd_data_q.rng_base;
	assign b_hit   = !b_above && !b_below;
	assign lo_n    = b_above ? mid_q + CW'(1) : lo_q;
	assign hx_n    = b_below ? mid_q : hx_q;

	assign l_hit = (req_q.code_point >= rd_data_q.rng_start) &&
		(req_q.code_point <= rd_data_q.rng_end);
	assign idx_n = idx_q + CW'(1);

	assign rsp_free = !rsp_vld_q || !rsp_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_n = S_EXEC;
			end
			S_EXEC: begin
				if ((req_q.op == OP_POS2CP) && (total_q != '0)) state_n = S_BRD;
				else if ((req_q.op == OP_CP2POS) && (total_q != '0)) state_n = S_LRD;
				else state_n = S_DONE;
			end
			S_BRD:  state_n = S_BCHK;
			S_BCHK: begin
				if (b_hit || (lo_n >= hx_n)) state_n = S_DONE;
				else state_n = S_BRD;
			end
			S_LRD:  state_n = S_LCHK;
			S_LCHK: begin
				if (l_hit || (idx_n == total_q)) state_n = S_DONE;
				else state_n = S_LRD;
			end
			S_DONE: begin
				if (rsp_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE);
		mem_we    = (state_q == S_EXEC) && (req_q.op == OP_APPEND) &&
			!app_bad && !app_full && !app_ovf;
		mem_re    = (state_q == S_BRD) || (state_q == S_LRD);
		rd_addr   = (state_q == S_BRD) ? mid_c[AW-1:0] : idx_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			range_mem_q[total_q[AW-1:0]] <= '{rng_start: req_q.range_start,
				rng_end: req_q.range_end, rng_base: npos_q[POS_W-1:0]};
		end
		if (mem_re) rd_data_q <= range_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			total_q   <= '0;
			npos_q    <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if ((state_q == S_EXEC) && (req_q.op == OP_CLEAR)) begin
				total_q <= '0;
				npos_q  <= '0;
			end else if (mem_we) begin
				total_q <= total_q + CW'(1);
				npos_q  <= app_sum[NP_W-1:0];
			end
			if ((state_q == S_DONE) && rsp_free) rsp_vld_q <= 1'b1;
			else if (!rsp_stall) rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) req_q <= req;
		if (state_q == S_EXEC) begin
			lo_q  <= '0;
			hx_q  <= total_q;
			idx_q <= '0;
			pend_cp_q  <= '0;
			pend_pos_q <= '0;
			unique case (req_q.op)
				OP_CLEAR: pend_status_q <= ST_OK;
				OP_APPEND: begin
					if (app_bad) pend_status_q <= ST_BAD_RANGE;
					else if (app_full) pend_status_q <= ST_FULL;
					else if (app_ovf) pend_status_q <= ST_OVERFLOW;
					else begin
						pend_status_q <= ST_OK;
						pend_pos_q    <= npos_q[POS_W-1:0];
					end
				end
				OP_POS2CP, OP_CP2POS: pend_status_q <= ST_NOT_FOUND;
				OP_LAST: begin
					if (total_q == '0) pend_status_q <= ST_EMPTY;
					else begin
						pend_status_q <= ST_OK;
						pend_pos_q    <= npos_q[POS_W-1:0] - POS_W'(1);
					end
				end
				default: pend_status_q <= ST_NOT_FOUND;
			endcase
		end
		if (state_q == S_BRD) mid_q <= mid_c;
		if (state_q == S_BCHK) begin
			lo_q <= lo_n;
			hx_q <= hx_n;
			if (b_hit) begin
				pend_status_q <= ST_OK;
				pend_cp_q <= rd_data_q.rng_start + (req_q.position - rd_data_q.rng_base);
			end
		end
		if (state_q == S_LCHK) begin
			idx_q <= idx_n;
			if (l_hit) begin
				pend_status_q <= ST_OK;
				pend_pos_q <= rd_data_q.rng_base + (req_q.code_point - rd_data_q.rng_start);
			end
		end
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_q.status         <= pend_status_q;
			rsp_q.code_point_out <= pend_cp_q;
			rsp_q.position_out   <= pend_pos_q;
			rsp_q.entries_used   <= ENT_W'(total_q);
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/crim_chk.sv =====
`default_nettype none

module crim_chk (
	input wire            clk,
	input wire            arst_n,
	input wire            req_valid,
	input wire            req_stall,
	input crim_pkg::req_t req,
	input wire            rsp_valid,
	input wire            rsp_stall,
	input crim_pkg::rsp_t rsp
);
	import crim_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_OVERFLOW)
		else $error("undefined status code");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
			(rsp.code_point_out == '0) && (rsp.position_out == '0))
		else $error("error response carries data");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.code_point_out == '0) || (rsp.position_out == '0))
		else $error("both code point and position set");

endmodule

bind codepoint_range_index_map crim_chk u_crim_chk (.*);

`default_nettype wire

// ===== tb/codepoint_range_index_map_test.sv =====
`timescale 1ns / 1ps

module codepoint_range_index_map_test;
	import crim_pkg::*;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned DRAIN_CYCLES = 600;
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned stall_hold = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;

	// table shadow
	logic [CP_W-1:0] held_start [TABLE_DEPTH];
	logic [CP_W-1:0] held_end [TABLE_DEPTH];
	logic [POS_W-1:0] held_base [TABLE_DEPTH];
	int unsigned held_count = 0;
	logic [NP_W-1:0] listed_total = '0;

	rsp_t owed_replies [$];
	rsp_t reply_want;

	codepoint_range_index_map dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("codepoint_range_index_map: mismatch");
			$finish;
		end
	end

	function automatic rsp_t apply_table_op(req_t item);
		rsp_t r;
		int lo;
		int hi;
		int mid;
		int unsigned b;
		int unsigned span_last;
		int unsigned size;
		bit hit;
		r = '0;
		r.status = ST_OK;
		hit = 1'b0;
		case (item.op)
			OP_CLEAR: begin
				held_count = 0;
				listed_total = '0;
			end
			OP_APPEND: begin
				if (item.range_end > MAX_CODE_POINT || item.range_start > item.range_end) begin
					r.status = ST_BAD_RANGE;
				end else if (held_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					size = item.range_end - item.range_start + 1;
					if (listed_total + size > POS_LIMIT) begin
						r.status = ST_OVERFLOW;
					end else begin
						held_start[held_count] = item.range_start;
						held_end[held_count] = item.range_end;
						held_base[held_count] = listed_total[POS_W-1:0];
						held_count++;
						r.position_out = listed_total[POS_W-1:0];
						listed_total = NP_W'(listed_total + size);
					end
				end
			end
			OP_POS2CP: begin
				lo = 0;
				hi = int'(held_count) - 1;
				while (!hit && hi >= lo) begin
					mid = (lo + hi) / 2;
					b = 32'(held_base[mid]);
					span_last = b + (held_end[mid] - held_start[mid]);
					if (item.position > span_last) begin
						lo = mid + 1;
					end else if (item.position < b) begin
						hi = mid - 1;
					end else begin
						r.code_point_out = CP_W'(held_start[mid] + (item.position - b));
						hit = 1'b1;
					end
				end
				if (!hit) r.status = ST_NOT_FOUND;
			end
			OP_CP2POS: begin
				for (int i = 0; i < int'(held_count) && !hit; i++) begin
					if (item.code_point >= held_start[i] && item.code_point <= held_end[i]) begin
						r.position_out = held_base[i] + (item.code_point - held_start[i]);
						hit = 1'b1;
					end
				end
				if (!hit) r.status = ST_NOT_FOUND;
			end
			OP_LAST: begin
				if (held_count == 0) r.status = ST_EMPTY;
				else r.position_out = POS_W'(listed_total - 1);
			end
			default: begin
				r.status = ST_NOT_FOUND;
			end
		endcase
		r.entries_used = held_count[ENT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_replies.size() == 0) begin
				$error("reply with none pending: status %0d", rsp.status);
				mismatches <= mismatches + 1;
			end else begin
				reply_want = owed_replies.pop_front();
				if (rsp !== reply_want) mismatches <= mismatches + 1;
				if (rsp.status !== reply_want.status)
					$error("status: expected %0d, got %0d", reply_want.status, rsp.status);
				if (rsp.code_point_out !== reply_want.code_point_out)
					$error("code_point_out: expected %0h, got %0h",
						reply_want.code_point_out, rsp.code_point_out);
				if (rsp.position_out !== reply_want.position_out)
					$error("position_out: expected %0h, got %0h",
						reply_want.position_out, rsp.position_out);
				if (rsp.entries_used !== reply_want.entries_used)
					$error("entries_used: expected %0d, got %0d",
						reply_want.entries_used, rsp.entries_used);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_hold != 0) begin
			rsp_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_beat(input req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		owed_replies.push_back(apply_table_op(item));
	endtask

	function automatic req_t make_req(logic [2:0] op, int unsigned first, int unsigned last,
			int unsigned pos, int unsigned cp);
		req_t item;
		item.op = op;
		item.range_start = CP_W'(first);
		item.range_end = CP_W'(last);
		item.position = POS_W'(pos);
		item.code_point = CP_W'(cp);
		return item;
	endfunction

	function automatic req_t pick_request();
		req_t item;
		int unsigned roll;
		int unsigned pick;
		int unsigned size;
		item.op = OP_LAST;
		item.range_start = CP_W'($urandom_range(MAX_CODE_POINT));
		item.range_end = CP_W'($urandom_range(MAX_CODE_POINT));
		item.position = POS_W'($urandom_range(21'h1FFFFF));
		item.code_point = CP_W'($urandom_range(MAX_CODE_POINT));
		roll = $urandom_range(99);
		if (roll < 3 || (held_count >= 48 && roll < 15)) begin
			item.op = OP_CLEAR;
		end else if (roll < 40) begin
			item.op = OP_APPEND;
			pick = $urandom_range(9);
			if (pick < 7) size = $urandom_range(256, 1);
			else if (pick < 9) size = $urandom_range(65536, 1);
			else size = $urandom_range(MAX_CODE_POINT + 1, 1);
			item.range_start = CP_W'($urandom_range(MAX_CODE_POINT + 1 - size));
			item.range_end = CP_W'(item.range_start + size - 1);
		end else if (roll < 62) begin
			item.op = OP_POS2CP;
			if (held_count != 0 && $urandom_range(4) != 0)
				item.position = POS_W'($urandom_range(listed_total - 1));
		end else if (roll < 84) begin
			item.op = OP_CP2POS;
			if (held_count != 0 && $urandom_range(4) != 0) begin
				pick = $urandom_range(held_count - 1);
				item.code_point = CP_W'($urandom_range(held_end[pick], held_start[pick]));
			end
		end else if (roll < 91) begin
			item.op = OP_LAST;
		end else begin
			pick = $urandom_range(3);
			if (pick == 0) begin
				item.op = OP_APPEND;
				item.range_end = CP_W'($urandom_range(21'h1FFFFF, MAX_CODE_POINT + 1));
			end else if (pick == 1) begin
				item.op = OP_APPEND;
				item.range_end = CP_W'($urandom_range(MAX_CODE_POINT - 1));
				item.range_start = CP_W'($urandom_range(MAX_CODE_POINT, item.range_end + 1));
			end else if (pick == 2) begin
				item.op = 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
			end else begin
				item.op = 3'($urandom_range(7));
			end
		end
		return item;
	endfunction

	task automatic test_empty_table();
		send_beat(make_req(OP_LAST, 0, 0, 0, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 0, 0));
		send_beat(make_req(OP_CP2POS, 0, 0, 0, 0));
		send_beat(make_req(OP_SPARE_A, 0, 0, 0, 0));
		send_beat(make_req(OP_SPARE_C, 0, 0, 0, 0));
		send_beat(make_req(OP_CLEAR, 0, 0, 0, 0));
	endtask

	task automatic test_edge_ranges();
		send_beat(make_req(OP_APPEND, 0, 0, 0, 0));
		send_beat(make_req(OP_APPEND, MAX_CODE_POINT, MAX_CODE_POINT, 0, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 1, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 2, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 21'h1FFFFF, 0));
		send_beat(make_req(OP_CP2POS, 0, 0, 0, MAX_CODE_POINT));
		send_beat(make_req(OP_CP2POS, 0, 0, 0, MAX_CODE_POINT - 1));
		send_beat(make_req(OP_LAST, 0, 0, 0, 0));
		send_beat(make_req(OP_APPEND, 0, MAX_CODE_POINT + 1, 0, 0));
		send_beat(make_req(OP_APPEND, 21'h1FFFFF, 21'h1FFFFF, 0, 0));
		send_beat(make_req(OP_APPEND, 5, 4, 0, 0));
		send_beat(make_req(OP_CLEAR, 0, 0, 0, 0));
		// two ranges that list exactly 2^21 code points
		send_beat(make_req(OP_APPEND, 0, MAX_CODE_POINT, 0, 0));
		send_beat(make_req(OP_APPEND, 0, 21'hEFFFF, 0, 0));
		send_beat(make_req(OP_APPEND, 0, 0, 0, 0));
		send_beat(make_req(OP_LAST, 0, 0, 0, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 21'h1FFFFF, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, 21'h110000, 0));
		send_beat(make_req(OP_CP2POS, 0, 0, 0, 21'hEFFFF));
		send_beat(make_req(OP_SPARE_B, 0, 0, 0, 0));
	endtask

	task automatic test_full_table();
		int unsigned first;
		int unsigned size;
		send_beat(make_req(OP_CLEAR, 0, 0, 0, 0));
		// code point 0 stays unlisted so a lookup of it walks every range
		send_beat(make_req(OP_APPEND, 1, MAX_CODE_POINT, 0, 0));
		send_beat(make_req(OP_APPEND, 1, 21'hE0000, 0, 0));
		for (int i = 2; i < TABLE_DEPTH; i++) begin
			size = $urandom_range(64, 1);
			first = $urandom_range(MAX_CODE_POINT + 1 - size, 1);
			send_beat(make_req(OP_APPEND, first, first + size - 1, 0, 0));
		end
		send_beat(make_req(OP_APPEND, 0, MAX_CODE_POINT, 0, 0));
		send_beat(make_req(OP_APPEND, 9, 8, 0, 0));
		send_beat(make_req(OP_CP2POS, 0, 0, 0, 0));
		send_beat(make_req(OP_POS2CP, 0, 0, listed_total - 1, 0));
		send_beat(make_req(OP_LAST, 0, 0, 0, 0));
		send_beat(make_req(OP_CLEAR, 0, 0, 0, 0));
	endtask

	task automatic test_stalled_replies();
		send_idle_pct = 0;
		stall_pct = 0;
		stall_hold = 400;
		repeat (12) send_beat(pick_request());
	endtask

	task automatic test_random_traffic();
		int unsigned idle_mix [4] = '{0, 48, 0, 9};
		int unsigned stall_mix [4] = '{0, 0, 48, 9};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			repeat (25) send_beat(pick_request());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_edge_ranges();
		test_full_table();
		test_stalled_replies();
		test_random_traffic();
		req_valid <= 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("codepoint_range_index_map: match");
		end else begin
			$display("codepoint_range_index_map: mismatch");
		end
		$finish;
	end

endmodule

// ===== codepoint_range_index_map.f =====
hw/rtl/crim_pkg.sv
hw/rtl/codepoint_range_index_map.sv
hw/rtl/crim_chk.sv
tb/codepoint_range_index_map_test.sv
